// ===== design/iptp_pkg.sv =====
// Shared types and helpers for the IP address text parser.
package iptp_pkg;

    // One character handed from the front end to the back end.
    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
        logic       first_char;
        logic       family;
        logic       is_digit;
        logic       is_hex;
        logic [3:0] hex_val;
        logic       is_colon;
        logic       is_dot;
    } iptp_item_t;

    localparam int QueueDepth = 2;

    function automatic logic [3:0] hex_of(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) v = 4'(c - 8'h30);
        else if (c >= 8'h61 && c <= 8'h66) v = 4'(c - 8'h61 + 8'd10);
        else if (c >= 8'h41 && c <= 8'h46) v = 4'(c - 8'h41 + 8'd10);
        return v;
    endfunction

endpackage

// ===== design/ip_address_text_parser_core.sv =====
// Top level of the IP address text parser: front end, queue and back end.
// One character is taken per clock cycle, back to back, and the result of a string
// is registered in the output register when the back end takes its last character;
// a two-entry queue separates the character classifier from the parse logic, so
// a stalled result holds up input only once that queue is full. IPv4 results sit in
// addr_low bits 31:0; a failed parse gives parse_ok low and an all-zero address.
module ip_address_text_parser_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  char_code,
    input  logic        last_char,
    input  logic        first_char,
    input  logic        family,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        parse_ok,
    output logic [63:0] addr_high,
    output logic [63:0] addr_low
);
    iptp_pkg::iptp_item_t q_item;
    logic q_valid, q_ready;

    iptp_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .char_code(char_code), .last_char(last_char), .first_char(first_char),
        .family(family), .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
    );

    iptp_back u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
        .out_valid(out_valid), .out_ready(out_ready), .parse_ok(parse_ok),
        .addr_high(addr_high), .addr_low(addr_low)
    );
endmodule

// ===== design/iptp_front.sv =====
// Front end: takes characters, classifies them and queues them for the back end.
module iptp_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           char_code,
    input  logic                 last_char,
    input  logic                 first_char,
    input  logic                 family,
    output logic                 q_valid,
    input  logic                 q_ready,
    output iptp_pkg::iptp_item_t q_item
);
    iptp_pkg::iptp_item_t mem_reg [iptp_pkg::QueueDepth];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    iptp_pkg::iptp_item_t cls;
    logic push, pop;

    always_comb
    begin
        cls.char_code  = char_code;
        cls.last_char  = last_char;
        cls.first_char = first_char;
        cls.family     = family;
        cls.is_digit   = (char_code >= 8'h30) && (char_code <= 8'h39);
        cls.is_hex     = cls.is_digit || (char_code >= 8'h61 && char_code <= 8'h66)
                         || (char_code >= 8'h41 && char_code <= 8'h46);
        cls.hex_val    = iptp_pkg::hex_of(char_code);
        cls.is_colon   = (char_code == 8'h3a);
        cls.is_dot     = (char_code == 8'h2e);
    end

    assign in_ready = (count_reg != 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = mem_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop) rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'd2) else $error("queue count overflow");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd2) |-> !push) else $error("push into full queue");
    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 2'd1))
        else $error("queue count lost a push");
endmodule

// ===== design/iptp_back.sv =====
// Back end: parse state machine and final address assembly.
module iptp_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  iptp_pkg::iptp_item_t q_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 parse_ok,
    output logic [63:0]          addr_high,
    output logic [63:0]          addr_low
);
    logic [7:0]  bytes_reg [16];
    logic [4:0]  write_pos_reg, gap_pos_reg;
    logic        gap_seen_reg;
    logic [15:0] group_value_reg;
    logic [2:0]  group_digits_reg;
    logic [7:0]  octet_value_reg;
    logic        octet_seen_reg;
    logic [2:0]  octet_count_reg;
    logic        tail_ok_reg, in_tail_reg, lead_colon_reg, failed_reg, family_reg;
    logic        out_valid_reg, ok_reg;
    logic [63:0] hi_reg, lo_reg;

    logic [7:0]  bytes_next [16];
    logic [4:0]  write_pos_next, gap_pos_next;
    logic        gap_seen_next;
    logic [15:0] group_value_next;
    logic [2:0]  group_digits_next;
    logic [7:0]  octet_value_next;
    logic        octet_seen_next;
    logic [2:0]  octet_count_next;
    logic        tail_ok_next, in_tail_next, lead_colon_next, failed_next, family_next;
    logic        ok_next;
    logic [63:0] hi_next, lo_next;
    logic        take;

    assign q_ready   = !out_valid_reg || out_ready;
    assign take      = q_valid && q_ready;
    assign out_valid = out_valid_reg;
    assign parse_ok  = ok_reg;
    assign addr_high = hi_reg;
    assign addr_low  = lo_reg;

    always_comb
    begin
        logic        ok, dec_ok, c_digit, first, last;
        logic [3:0]  d;
        logic [11:0] nv;
        logic [4:0]  base, pos, gp, n, src;
        logic [7:0]  tmp [16];
        logic [7:0]  res [16];
        logic        fin_ok;
        base = 5'd0; gp = 5'd0; n = 5'd0; src = 5'd0;
        res = bytes_reg;
        bytes_next        = bytes_reg;
        write_pos_next    = write_pos_reg;
        gap_pos_next      = gap_pos_reg;
        gap_seen_next     = gap_seen_reg;
        group_value_next  = group_value_reg;
        group_digits_next = group_digits_reg;
        octet_value_next  = octet_value_reg;
        octet_seen_next   = octet_seen_reg;
        octet_count_next  = octet_count_reg;
        tail_ok_next      = tail_ok_reg;
        in_tail_next      = in_tail_reg;
        lead_colon_next   = lead_colon_reg;
        failed_next       = failed_reg;
        family_next       = family_reg;
        ok = 1'b1;
        first   = q_item.first_char;
        last    = q_item.last_char;
        c_digit = q_item.is_digit;
        d       = q_item.hex_val;
        if (first)
        begin
            for (int i = 0; i < 16; i++) bytes_next[i] = 8'd0;
            write_pos_next = 5'd0; gap_pos_next = 5'd0; gap_seen_next = 1'b0;
            group_value_next = 16'd0; group_digits_next = 3'd0;
            octet_value_next = 8'd0; octet_seen_next = 1'b0; octet_count_next = 3'd0;
            tail_ok_next = 1'b1; in_tail_next = 1'b0; lead_colon_next = 1'b0;
            failed_next = 1'b0; family_next = q_item.family;
        end
        // Shared decimal-digit step of the dotted-quad rules.
        nv = 12'(octet_value_next) * 12'd10 + 12'(d);
        dec_ok = !(octet_seen_next && octet_value_next == 8'd0) && (nv <= 12'd255)
                 && (octet_seen_next || octet_count_next != 3'd4);
        if (!failed_next)
        begin
            if (!family_next || in_tail_next)
            begin
                base = family_next ? write_pos_next : 5'd12;
                if (c_digit)
                begin
                    if (!dec_ok) ok = 1'b0;
                    else
                    begin
                        if (!octet_seen_next) octet_count_next = octet_count_next + 3'd1;
                        octet_seen_next = 1'b1;
                        octet_value_next = nv[7:0];
                        bytes_next[4'(base + 5'(octet_count_next) - 5'd1)] = nv[7:0];
                    end
                end
                else if (q_item.is_dot && octet_seen_next)
                begin
                    if (octet_count_next == 3'd4) ok = 1'b0;
                    else
                    begin
                        octet_value_next = 8'd0; octet_seen_next = 1'b0;
                    end
                end
                else ok = 1'b0;
            end
            else if (first && q_item.is_colon)
            begin
                ok = !last; lead_colon_next = 1'b1;
            end
            else if (lead_colon_next && !q_item.is_colon)
            begin
                ok = 1'b0; lead_colon_next = 1'b0;
            end
            else
            begin
                lead_colon_next = 1'b0;
                if (q_item.is_hex)
                begin
                    if (group_digits_next == 3'd4) ok = 1'b0;
                    else
                    begin
                        group_value_next = {group_value_next[11:0], d};
                        group_digits_next = group_digits_next + 3'd1;
                        if (tail_ok_next)
                        begin
                            if (!c_digit || !dec_ok) tail_ok_next = 1'b0;
                            else
                            begin
                                if (!octet_seen_next)
                                    octet_count_next = octet_count_next + 3'd1;
                                octet_seen_next = 1'b1;
                                octet_value_next = nv[7:0];
                            end
                        end
                    end
                end
                else if (q_item.is_colon)
                begin
                    octet_value_next = 8'd0; octet_seen_next = 1'b0;
                    octet_count_next = 3'd0; tail_ok_next = 1'b1;
                    if (group_digits_next == 3'd0)
                    begin
                        if (gap_seen_next) ok = 1'b0;
                        else
                        begin
                            gap_seen_next = 1'b1; gap_pos_next = write_pos_next;
                        end
                    end
                    else if (last || write_pos_next > 5'd14) ok = 1'b0;
                    else
                    begin
                        bytes_next[write_pos_next[3:0]] = group_value_next[15:8];
                        bytes_next[4'(write_pos_next + 5'd1)] = group_value_next[7:0];
                        write_pos_next = write_pos_next + 5'd2;
                        group_value_next = 16'd0; group_digits_next = 3'd0;
                    end
                end
                else if (q_item.is_dot)
                begin
                    if (!tail_ok_next || !octet_seen_next || write_pos_next > 5'd12)
                        ok = 1'b0;
                    else
                    begin
                        bytes_next[write_pos_next[3:0]] = octet_value_next;
                        octet_value_next = 8'd0; octet_seen_next = 1'b0;
                        in_tail_next = 1'b1;
                    end
                end
                else ok = 1'b0;
            end
            if (!ok) failed_next = 1'b1;
        end

        // Final assembly, used only on the last character.
        tmp = bytes_next;
        pos = write_pos_next;
        fin_ok = !failed_next;
        if (fin_ok && !family_next) fin_ok = (octet_count_next == 3'd4);
        else if (fin_ok)
        begin
            if (in_tail_next)
            begin
                if (octet_count_next < 3'd4) fin_ok = 1'b0;
                else pos = pos + 5'd4;
            end
            else if (group_digits_next != 3'd0)
            begin
                if (pos > 5'd14) fin_ok = 1'b0;
                else
                begin
                    tmp[pos[3:0]] = group_value_next[15:8];
                    tmp[4'(pos + 5'd1)] = group_value_next[7:0];
                    pos = pos + 5'd2;
                end
            end
            if (fin_ok && gap_seen_next)
            begin
                if (pos > 5'd16) pos = 5'd16;
                gp = (gap_pos_next > pos) ? pos : gap_pos_next;
                if (pos == 5'd16) fin_ok = 1'b0;
                else
                begin
                    n = pos - gp;
                    // Bytes below the gap stay, bytes of the tail move to the end.
                    for (int i = 0; i < 16; i++)
                    begin
                        src = 5'(i) - (5'd16 - n) + gp;
                        if (5'(i) < gp) res[i] = tmp[i];
                        else if (5'(i) >= 5'd16 - n) res[i] = tmp[src[3:0]];
                        else res[i] = 8'd0;
                    end
                    tmp = res;
                    pos = 5'd16;
                end
            end
            if (fin_ok && pos != 5'd16) fin_ok = 1'b0;
        end
        ok_next = fin_ok;
        hi_next = 64'd0;
        lo_next = 64'd0;
        if (fin_ok)
        begin
            for (int i = 0; i < 8; i++)
            begin
                hi_next[63 - 8*i -: 8] = tmp[i];
                lo_next[63 - 8*i -: 8] = tmp[i + 8];
            end
            if (!family_next)
            begin
                hi_next = 64'd0; lo_next[63:32] = 32'd0;
            end
        end
        if (last) failed_next = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (take && q_item.last_char)
        begin
            ok_reg <= ok_next;
            hi_reg <= hi_next;
            lo_reg <= lo_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++) bytes_reg[i] <= 8'd0;
            write_pos_reg <= 5'd0; gap_pos_reg <= 5'd0; gap_seen_reg <= 1'b0;
            group_value_reg <= 16'd0; group_digits_reg <= 3'd0;
            octet_value_reg <= 8'd0; octet_seen_reg <= 1'b0; octet_count_reg <= 3'd0;
            tail_ok_reg <= 1'b1; in_tail_reg <= 1'b0; lead_colon_reg <= 1'b0;
            failed_reg <= 1'b0; family_reg <= 1'b0; out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                bytes_reg <= bytes_next;
                write_pos_reg <= write_pos_next; gap_pos_reg <= gap_pos_next;
                gap_seen_reg <= gap_seen_next; group_value_reg <= group_value_next;
                group_digits_reg <= group_digits_next;
                octet_value_reg <= octet_value_next; octet_seen_reg <= octet_seen_next;
                octet_count_reg <= octet_count_next; tail_ok_reg <= tail_ok_next;
                in_tail_reg <= in_tail_next; lead_colon_reg <= lead_colon_next;
                failed_reg <= failed_next; family_reg <= family_next;
            end
            if (take && q_item.last_char) out_valid_reg <= 1'b1;
            else if (out_ready) out_valid_reg <= 1'b0;
        end
    end

    a_fail_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (take && q_item.last_char) |=> failed_reg) else $error("failed not set after last");
    a_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !ok_reg) |-> (hi_reg == 64'd0 && lo_reg == 64'd0))
        else $error("address not zero on failure");
    a_write_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        write_pos_reg <= 5'd16) else $error("write position beyond address");
endmodule

// ===== dv/tb_ip_address_text_parser_core.sv =====
// Self-checking testbench for the streaming IPv4/IPv6 text address parser.
`timescale 1ns / 1ps

module tb_ip_address_text_parser_core;

    localparam int ClkPeriod   = 10;
    localparam int CycleLimit  = 400000;
    localparam int RandStrings = 112;

    localparam logic FamV4 = 1'b0;
    localparam logic FamV6 = 1'b1;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
        logic       first_char;
        logic       family;
    } char_xfer_t;

    typedef struct packed {
        logic        parse_ok;
        logic [63:0] addr_high;
        logic [63:0] addr_low;
    } addr_result_t;

    // Typed-in result for one string, used in place of the predictor when present.
    typedef struct packed {
        logic         has_known;
        addr_result_t res;
    } known_t;

    // A row of the directed table: one whole string, with an optional typed-in result.
    typedef struct {
        string       text;
        logic        fam;
        logic        has_known;
        logic        known_ok;
        logic [63:0] known_high;
        logic [63:0] known_low;
    } addr_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  char_code;
    logic        last_char;
    logic        first_char;
    logic        family;
    logic        out_valid;
    logic        out_ready;
    logic        parse_ok;
    logic [63:0] addr_high;
    logic [63:0] addr_low;

    ip_address_text_parser_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .char_code  (char_code),
        .last_char  (last_char),
        .first_char (first_char),
        .family     (family),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .parse_ok   (parse_ok),
        .addr_high  (addr_high),
        .addr_low   (addr_low)
    );

    // Predictor state.
    logic [7:0]  pb_bytes [16];
    int unsigned pb_wpos, pb_gpos, pb_gseen;
    int unsigned pb_gval, pb_gdig;
    int unsigned pb_oval, pb_oseen, pb_ocnt;
    int unsigned pb_dok, pb_intail, pb_lcolon;
    int unsigned pb_failed, pb_fam;

    addr_result_t expected_addrs [$];
    char_xfer_t   char_stream [$];
    known_t       last_known [$];
    int           mismatches;
    int           cycles;
    logic         stim_done;

    initial clk = 1'b0;
    always #(ClkPeriod / 2) clk = ~clk;

    function automatic void clear_parse_state();
        for (int i = 0; i < 16; i++) pb_bytes[i] = 8'h00;
        pb_wpos = 0; pb_gpos = 0; pb_gseen = 0;
        pb_gval = 0; pb_gdig = 0;
        pb_oval = 0; pb_oseen = 0; pb_ocnt = 0;
        pb_dok = 1; pb_intail = 0; pb_lcolon = 0;
        pb_failed = 0;
    endfunction

    function automatic bit take_decimal(int unsigned d);
        int unsigned nv;
        if (pb_oseen != 0 && pb_oval == 0) return 1'b0;
        nv = pb_oval * 10 + d;
        if (nv > 255) return 1'b0;
        if (pb_oseen == 0) begin
            if (pb_ocnt + 1 > 4) return 1'b0;
            pb_ocnt++;
            pb_oseen = 1;
        end
        pb_oval = nv;
        return 1'b1;
    endfunction

    function automatic bit dotted_step(int unsigned c, int unsigned base);
        if (c >= "0" && c <= "9") begin
            if (!take_decimal(c - "0")) return 1'b0;
            pb_bytes[(base + pb_ocnt - 1) & 15] = pb_oval[7:0];
            return 1'b1;
        end
        if (c == "." && pb_oseen != 0) begin
            if (pb_ocnt == 4) return 1'b0;
            pb_oval = 0;
            pb_oseen = 0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic int unsigned hex_digit_of(int unsigned c);
        if (c >= "0" && c <= "9") return c - "0";
        if (c >= "a" && c <= "f") return c - "a" + 10;
        if (c >= "A" && c <= "F") return c - "A" + 10;
        return 16;
    endfunction

    function automatic bit group_step(int unsigned c, bit is_last);
        int unsigned h;
        if (pb_lcolon != 0) begin
            pb_lcolon = 0;
            if (c != ":") return 1'b0;
        end
        h = hex_digit_of(c);
        if (h < 16) begin
            if (pb_gdig == 4) return 1'b0;
            pb_gval = ((pb_gval << 4) | h) & 32'hffff;
            pb_gdig++;
            if (pb_dok != 0) begin
                if (c > "9" || !take_decimal(c - "0")) pb_dok = 0;
            end
            return 1'b1;
        end
        if (c == ":") begin
            pb_oval = 0; pb_oseen = 0; pb_ocnt = 0;
            pb_dok = 1;
            if (pb_gdig == 0) begin
                if (pb_gseen != 0) return 1'b0;
                pb_gseen = 1;
                pb_gpos = pb_wpos;
                return 1'b1;
            end
            if (is_last) return 1'b0;
            if (pb_wpos + 2 > 16) return 1'b0;
            pb_bytes[pb_wpos & 15] = pb_gval[15:8];
            pb_bytes[(pb_wpos + 1) & 15] = pb_gval[7:0];
            pb_wpos += 2;
            pb_gval = 0; pb_gdig = 0;
            return 1'b1;
        end
        if (c == ".") begin
            if (pb_dok == 0 || pb_oseen == 0 || pb_wpos > 12) return 1'b0;
            pb_bytes[pb_wpos & 15] = pb_oval[7:0];
            pb_oval = 0; pb_oseen = 0;
            pb_intail = 1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Advances the parser copy by one character; returns 1 with a result on the last one.
    function automatic bit parse_char(input char_xfer_t x, output addr_result_t r);
        int unsigned c, pos, gp, n;
        logic [7:0]  tmp [16];
        logic [7:0]  sh  [16];
        bit          ok;
        c = x.char_code;
        r = '0;
        if (x.first_char) begin
            clear_parse_state();
            pb_fam = x.family;
        end
        if (pb_failed == 0) begin
            if (pb_fam == 0) ok = dotted_step(c, 12);
            else if (pb_intail != 0) ok = dotted_step(c, pb_wpos);
            else if (x.first_char && c == ":") begin
                ok = !x.last_char;
                pb_lcolon = 1;
            end
            else ok = group_step(c, x.last_char);
            if (!ok) pb_failed = 1;
        end
        if (!x.last_char) return 1'b0;
        tmp = pb_bytes;
        pos = pb_wpos;
        ok = (pb_failed == 0);
        if (ok && pb_fam == 0) begin
            ok = (pb_ocnt == 4);
        end
        else if (ok) begin
            if (pb_intail != 0) begin
                if (pb_ocnt < 4) ok = 1'b0; else pos += 4;
            end
            else if (pb_gdig > 0) begin
                if (pos + 2 > 16) ok = 1'b0;
                else begin
                    tmp[pos & 15] = pb_gval[15:8];
                    tmp[(pos + 1) & 15] = pb_gval[7:0];
                    pos += 2;
                end
            end
            if (ok && pb_gseen != 0) begin
                gp = pb_gpos;
                if (pos > 16) pos = 16;
                if (gp > pos) gp = pos;
                if (pos == 16) ok = 1'b0;
                else begin
                    n = pos - gp;
                    sh = tmp;
                    for (int i = 0; i < 16; i++) begin
                        if (i < gp) sh[i] = tmp[i];
                        else if (i >= 16 - n) sh[i] = tmp[gp + i - (16 - n)];
                        else sh[i] = 8'h00;
                    end
                    tmp = sh;
                    pos = 16;
                end
            end
            if (ok && pos != 16) ok = 1'b0;
        end
        if (ok) begin
            for (int i = 0; i < 8; i++) begin
                r.addr_high = {r.addr_high[55:0], tmp[i]};
                r.addr_low  = {r.addr_low[55:0], tmp[i + 8]};
            end
            if (pb_fam == 0) begin
                r.addr_high = '0;
                r.addr_low[63:32] = '0;
            end
        end
        r.parse_ok = ok;
        pb_failed = 1;
        return 1'b1;
    endfunction

    function automatic void queue_string(string s, logic fam, known_t kn);
        char_xfer_t x;
        for (int i = 0; i < s.len(); i++) begin
            x.char_code  = s[i];
            x.first_char = (i == 0);
            x.last_char  = (i == s.len() - 1);
            x.family     = fam;
            char_stream.push_back(x);
            if (x.last_char) last_known.push_back(kn);
        end
    endfunction

    function automatic string rand_octet();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0) return $sformatf("%0d", $urandom_range(256, 999));
        if (k == 1) return $sformatf("0%0d", $urandom_range(0, 99));
        if (k == 2) return "255";
        return $sformatf("%0d", $urandom_range(0, 255));
    endfunction

    function automatic string rand_v4();
        string s;
        int    n;
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 5) : 4;
        s = rand_octet();
        for (int i = 1; i < n; i++) s = {s, ".", rand_octet()};
        return s;
    endfunction

    function automatic string rand_group();
        string s, d;
        int    n;
        n = $urandom_range(1, ($urandom_range(0, 15) == 0) ? 5 : 4);
        s = "";
        for (int i = 0; i < n; i++) begin
            d = $urandom_range(0, 1) ? "0123456789abcdef" : "0123456789ABCDEF";
            s = {s, string'(d[$urandom_range(0, 15)])};
        end
        return s;
    endfunction

    function automatic string rand_v6();
        string s;
        int    n, gap, tail;
        tail = ($urandom_range(0, 3) == 0);
        n = $urandom_range(0, tail ? 6 : 8);
        gap = ($urandom_range(0, 2) != 0) ? $urandom_range(0, n) : -1;
        if ($urandom_range(0, 7) == 0) n = n + 1;
        s = "";
        for (int i = 0; i < n; i++) begin
            if (i == gap) s = {s, "::"};
            else if (i != 0) s = {s, ":"};
            s = {s, rand_group()};
        end
        if (gap == n || gap < 0 && n == 0) s = {s, "::"};
        if (tail) begin
            if (s.len() != 0 && s[s.len() - 1] != ":") s = {s, ":"};
            s = {s, rand_v4()};
        end
        if (s.len() == 0) s = "::";
        return s;
    endfunction

    function automatic string rand_noise();
        string s;
        int    n;
        string pool;
        pool = "0123456789abcdefABCDEFg:.::.. ";
        n = $urandom_range(1, 12);
        s = "";
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 4) == 0) s = {s, string'(8'($urandom_range(1, 255)))};
            else s = {s, string'(pool[$urandom_range(0, pool.len() - 1)])};
        end
        return s;
    endfunction

    // Sender: walks the character stream, predicting at each accepted transfer.
    initial begin
        char_xfer_t   x;
        addr_result_t r;
        addr_row_t    rows [$];
        known_t       kn;
        int           nwait;
        rows = '{
            '{"0.0.0.0",         FamV4, 1, 1, 64'h0, 64'h0},
            '{"255.255.255.255", FamV4, 1, 1, 64'h0, 64'hffffffff},
            '{"1.2.3.4",         FamV4, 1, 1, 64'h0, 64'h01020304},
            '{"256.1.1.1",       FamV4, 1, 0, 64'h0, 64'h0},
            '{"01.2.3.4",        FamV4, 1, 0, 64'h0, 64'h0},
            '{"1.2.3",           FamV4, 1, 0, 64'h0, 64'h0},
            '{"1.2.3.4.5",       FamV4, 1, 0, 64'h0, 64'h0},
            '{"7",               FamV4, 1, 0, 64'h0, 64'h0},
            '{"::",              FamV6, 1, 1, 64'h0, 64'h0},
            '{"::1",             FamV6, 1, 1, 64'h0, 64'h1},
            '{":",               FamV6, 1, 0, 64'h0, 64'h0},
            '{"1::",             FamV6, 0, 0, 64'h0, 64'h0},
            '{"1:",              FamV6, 1, 0, 64'h0, 64'h0},
            '{":1::2",           FamV6, 1, 0, 64'h0, 64'h0},
            '{"1::2::3",         FamV6, 1, 0, 64'h0, 64'h0},
            '{"12345::",         FamV6, 1, 0, 64'h0, 64'h0},
            '{"ffff:FFFF:ffff:ffff:ffff:ffff:ffff:ffff", FamV6, 1, 1, '1, '1},
            '{"1:2:3:4:5:6:7:8:9", FamV6, 1, 0, 64'h0, 64'h0},
            '{"::ffff:1.2.3.4",  FamV6, 0, 0, 64'h0, 64'h0},
            '{"1:2:3:4:5:6:7.7.7.7", FamV6, 0, 0, 64'h0, 64'h0},
            '{"::1.2.3",         FamV6, 1, 0, 64'h0, 64'h0},
            '{"a:b:c:d:e:f:0:1", FamV6, 0, 0, 64'h0, 64'h0},
            '{"1.2.3.x",         FamV4, 1, 0, 64'h0, 64'h0}
        };
        in_valid = 1'b0; char_code = '0; last_char = 1'b0;
        first_char = 1'b0; family = 1'b0;
        stim_done = 1'b0;
        pb_fam = 0;
        clear_parse_state();
        // Every one of the hand-built characters below ends in a failed parse.
        kn = '0;
        kn.has_known = 1'b1;
        // Characters before any first character, then a string missing its start.
        x = '{char_code: "5", last_char: 1'b0, first_char: 1'b0, family: FamV4};
        char_stream.push_back(x);
        x.char_code = 8'h00; x.last_char = 1'b1;
        char_stream.push_back(x);
        last_known.push_back(kn);
        x.char_code = 8'hff;
        char_stream.push_back(x);
        last_known.push_back(kn);
        // Single characters with both flags set, with the codes ff and 80 hex.
        x = '{char_code: 8'hff, last_char: 1'b1, first_char: 1'b1, family: FamV6};
        char_stream.push_back(x);
        last_known.push_back(kn);
        x.char_code = 8'h80; x.family = FamV4;
        char_stream.push_back(x);
        last_known.push_back(kn);
        foreach (rows[i]) begin
            kn.has_known = rows[i].has_known;
            kn.res = '{parse_ok: rows[i].known_ok, addr_high: rows[i].known_high,
                       addr_low: rows[i].known_low};
            queue_string(rows[i].text, rows[i].fam, kn);
        end
        kn = '0;
        for (int i = 0; i < RandStrings; i++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: queue_string(rand_v4(), FamV4, kn);
                4, 5, 6, 7: queue_string(rand_v6(), FamV6, kn);
                8:          queue_string(rand_noise(), FamV6, kn);
                default:    queue_string(rand_noise(), FamV4, kn);
            endcase
        end
        @(posedge rst_n);
        while (char_stream.size() > 0) begin
            x = char_stream.pop_front();
            nwait = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
            if (nwait > 0) begin
                in_valid <= 1'b0;
                repeat (nwait) @(posedge clk);
            end
            in_valid   <= 1'b1;
            char_code  <= x.char_code;
            last_char  <= x.last_char;
            first_char <= x.first_char;
            family     <= x.family;
            @(posedge clk);
            while (!in_ready) @(posedge clk);
            if (parse_char(x, r)) begin
                kn = last_known.pop_front();
                if (kn.has_known) expected_addrs.push_back(kn.res);
                else expected_addrs.push_back(r);
            end
        end
        in_valid <= 1'b0;
        stim_done = 1'b1;
    end

    // Receiver with random stalls.
    initial begin
        int nwait;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever begin
            nwait = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
            if (nwait > 0) begin
                out_ready <= 1'b0;
                repeat (nwait) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    // Checker: compares each result transfer with the oldest expectation.
    always @(posedge clk) begin
        addr_result_t e;
        if (rst_n && out_valid && out_ready) begin
            if (expected_addrs.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: ok=%0b high=%h low=%h",
                             parse_ok, addr_high, addr_low);
            end
            else begin
                e = expected_addrs.pop_front();
                if (e.parse_ok !== parse_ok || e.addr_high !== addr_high
                        || e.addr_low !== addr_low) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: expected ok=%0b high=%h low=%h, ",
                                  "got ok=%0b high=%h low=%h"},
                                 e.parse_ok, e.addr_high, e.addr_low,
                                 parse_ok, addr_high, addr_low);
                end
            end
        end
    end

    initial begin
        mismatches = 0;
        cycles = 0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        forever begin
            @(posedge clk);
            cycles++;
            if (cycles >= CycleLimit) begin
                $display("ip_address_text_parser_core test failed");
                $finish;
            end
            if (stim_done && expected_addrs.size() == 0) begin
                repeat (20) @(posedge clk);
                if (mismatches == 0 && expected_addrs.size() == 0)
                    $display("ip_address_text_parser_core test passed");
                else
                    $display("ip_address_text_parser_core test failed");
                $finish;
            end
        end
    end

endmodule
